// ===== rtl/core/tstab_pkg.sv =====
// shared types, codes and constants of the tempo segment table
`default_nettype none
package tstab_pkg;

    localparam int unsigned MAX_SEGMENTS_DEF = 16;

    localparam int unsigned TIME_W  = 24;
    localparam int unsigned BPM_W   = 10;
    localparam int unsigned START_W = 25;
    localparam int unsigned INDEX_W = 4;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [BPM_W-1:0]  INSERT_BPM_FALLBACK = 10'd100;
    localparam logic [BPM_W-1:0]  RESET_DEFAULT_BPM   = 10'd120;
    localparam logic [TIME_W-1:0] RESET_DEFAULT_OFS   = 24'd0;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEFAULT_BPM = 2'd0,
        CFG_DEFAULT_OFS = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [BPM_W-1:0]  bpm;
    } t_entry;

    typedef enum logic [1:0] { RD_IDX, RD_IDX_M1, RD_IDX_P1 } t_rd_sel;
    typedef enum logic { WR_SHIFT, WR_NEW } t_wr_sel;
    typedef enum logic [2:0] {
        IDX_HOLD, IDX_CLR, IDX_INC, IDX_DEC, IDX_COUNT, IDX_POS
    } t_idx_op;
    typedef enum logic [1:0] { POS_HOLD, POS_IDX, POS_DEC, POS_LAST } t_pos_op;
    typedef enum logic [1:0] { CNT_HOLD, CNT_INC, CNT_DEC } t_cnt_op;
    typedef enum logic [2:0] {
        RES_DEFAULT, RES_EMPTY, RES_HIT, RES_NEW, RES_FULL
    } t_res_sel;

    typedef struct packed {
        logic     load_item;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wr_sel  wr_sel;
        t_idx_op  idx_op;
        t_pos_op  pos_op;
        t_cnt_op  cnt_op;
        logic     hit_cap;
        logic     res_load;
        t_res_sel res_sel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       cnt_zero;
        logic       cnt_one;
        logic       full;
        logic       less;
        logic       idx_eq_cnt;
        logic       idx_eq_pos;
        logic       idx_p1_lt_cnt;
        logic       pos_zero;
        logic       pos_eq_cnt;
        logic       out_free;
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/core/tempo_segment_table_unit.sv =====
// top level of the sorted tempo segment table
//
// usage:
// - input channel (i_in_valid / o_in_ready) carries one transaction per
//   operation: lookup, insert or remove keyed by i_time_ms
// - output channel (o_out_valid / i_out_ready) returns exactly one result
//   transaction per operation, in order
// - config channel (i_cfg_valid / o_cfg_ready) writes the default tempo
//   (index 0) and default offset (index 1); always ready, use while idle
// - one operation at a time; run time is set by the single-port segment
//   memory: the scan reads and compares one entry at a time up to the
//   sorted position, and each shift step past it is one read plus one write
// - quick cases (full insert, empty table) go from dispatch straight to
//   the finish state
// - result sits in an output register; the next operation is taken while
//   it waits, and that one stalls only at its own result until it drains
// - reset clears the entry count and loads the default registers; memory
//   contents are never read above the count, so no clearing pass is needed
`default_nettype none
module tempo_segment_table_unit #(
    parameter int unsigned MAX_SEGMENTS = tstab_pkg::MAX_SEGMENTS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // operation transaction
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [1:0]                            i_op,
    input  wire logic [tstab_pkg::TIME_W-1:0]          i_time_ms,
    input  wire logic [tstab_pkg::BPM_W-1:0]           i_tempo_bpm,
    // configuration write transaction
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [tstab_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [tstab_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // result transaction
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [tstab_pkg::BPM_W-1:0]                o_seg_bpm,
    output logic signed [tstab_pkg::START_W-1:0]       o_seg_start_ms,
    output logic                                       o_is_default,
    output logic [tstab_pkg::INDEX_W-1:0]              o_seg_index,
    output logic [tstab_pkg::COUNT_W-1:0]              o_seg_count,
    output logic [1:0]                                 o_status
);
    import tstab_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // config registers never back-pressure
    assign o_cfg_ready = 1'b1;

    // sequencer: scan for the sorted position, fetch, then shift
    tstab_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // segment memory, counters and result register
    tstab_dpath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_op           (i_op),
        .i_time_ms      (i_time_ms),
        .i_tempo_bpm    (i_tempo_bpm),
        .i_cfg_wr       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_seg_bpm      (o_seg_bpm),
        .o_seg_start_ms (o_seg_start_ms),
        .o_is_default   (o_is_default),
        .o_seg_index    (o_seg_index),
        .o_seg_count    (o_seg_count),
        .o_status       (o_status)
    );

endmodule
`default_nettype wire

// ===== rtl/core/tstab_ctrl.sv =====
// sequencer for scan, fetch and shift of the tempo segment table
`default_nettype none
module tstab_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire tstab_pkg::t_stat i_stat,
    output tstab_pkg::t_cmd       o_cmd
);
    import tstab_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CMP, S_POST_SCAN, S_GET_SETUP,
        S_GET_RD, S_GET_CAP, S_REM_RD, S_REM_WR, S_INS_RD, S_INS_WR,
        S_INS_NEW, S_FINISH
    } t_state;

    t_state   r_state, n_state;
    t_res_sel r_res_sel, n_res_sel;
    t_cmd     cmd;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_res_sel <= RES_DEFAULT;
        end else begin
            r_state   <= n_state;
            r_res_sel <= n_res_sel;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_res_sel = r_res_sel;
        cmd           = '0;
        cmd.rd_sel    = RD_IDX;
        cmd.wr_sel    = WR_SHIFT;
        cmd.idx_op    = IDX_HOLD;
        cmd.pos_op    = POS_HOLD;
        cmd.cnt_op    = CNT_HOLD;
        cmd.res_sel   = r_res_sel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_item = 1'b1;
                    cmd.idx_op    = IDX_CLR;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.op)
                    OP_INSERT: begin
                        if (i_stat.full) begin
                            n_res_sel = RES_FULL;
                            n_state   = S_FINISH;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end
                    OP_REMOVE: begin
                        if (i_stat.cnt_zero) begin
                            n_res_sel = RES_EMPTY;
                            n_state   = S_FINISH;
                        end else if (i_stat.cnt_one) begin
                            // single entry goes whatever the time
                            cmd.pos_op = POS_IDX;
                            n_state    = S_GET_RD;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end
                    default: begin
                        if (i_stat.cnt_zero) begin
                            n_res_sel = RES_DEFAULT;
                            n_state   = S_FINISH;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end
                endcase
            end
            S_SCAN_RD: begin
                if (i_stat.idx_eq_cnt) begin
                    cmd.pos_op = POS_IDX;
                    n_state    = S_POST_SCAN;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    n_state    = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_stat.less) begin
                    cmd.pos_op = POS_IDX;
                    n_state    = S_POST_SCAN;
                end else begin
                    cmd.idx_op = IDX_INC;
                    n_state    = S_SCAN_RD;
                end
            end
            S_POST_SCAN: begin
                case (i_stat.op)
                    OP_INSERT: begin
                        cmd.idx_op = IDX_COUNT;
                        n_state    = S_INS_RD;
                    end
                    OP_REMOVE: begin
                        if (i_stat.pos_eq_cnt) begin
                            cmd.pos_op = POS_LAST;
                        end else if (!i_stat.pos_zero) begin
                            cmd.pos_op = POS_DEC;
                        end
                        n_state = S_GET_SETUP;
                    end
                    default: begin
                        if (i_stat.pos_zero) begin
                            n_res_sel = RES_DEFAULT;
                            n_state   = S_FINISH;
                        end else begin
                            cmd.pos_op = POS_DEC;
                            n_state    = S_GET_SETUP;
                        end
                    end
                endcase
            end
            S_GET_SETUP: begin
                cmd.idx_op = IDX_POS;
                n_state    = S_GET_RD;
            end
            S_GET_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX;
                n_state    = S_GET_CAP;
            end
            S_GET_CAP: begin
                cmd.hit_cap = 1'b1;
                n_res_sel   = RES_HIT;
                if (i_stat.op == OP_REMOVE) begin
                    n_state = S_REM_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_REM_RD: begin
                if (i_stat.idx_p1_lt_cnt) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_P1;
                    n_state    = S_REM_WR;
                end else begin
                    cmd.cnt_op = CNT_DEC;
                    n_state    = S_FINISH;
                end
            end
            S_REM_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                cmd.idx_op = IDX_INC;
                n_state    = S_REM_RD;
            end
            S_INS_RD: begin
                if (i_stat.idx_eq_pos) begin
                    n_state = S_INS_NEW;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_M1;
                    n_state    = S_INS_WR;
                end
            end
            S_INS_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                cmd.idx_op = IDX_DEC;
                n_state    = S_INS_RD;
            end
            S_INS_NEW: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_NEW;
                cmd.cnt_op = CNT_INC;
                n_res_sel  = RES_NEW;
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    cmd.res_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/tstab_dpath.sv =====
// segment memory, counters, config registers and result register
`default_nettype none
module tstab_dpath #(
    parameter int unsigned MAX_SEGMENTS = tstab_pkg::MAX_SEGMENTS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire tstab_pkg::t_cmd                       i_cmd,
    output tstab_pkg::t_stat                           o_stat,
    input  wire logic [1:0]                            i_op,
    input  wire logic [tstab_pkg::TIME_W-1:0]          i_time_ms,
    input  wire logic [tstab_pkg::BPM_W-1:0]           i_tempo_bpm,
    input  wire logic                                  i_cfg_wr,
    input  wire logic [tstab_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [tstab_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                  i_out_ready,
    output logic                                       o_out_valid,
    output logic [tstab_pkg::BPM_W-1:0]                o_seg_bpm,
    output logic signed [tstab_pkg::START_W-1:0]       o_seg_start_ms,
    output logic                                       o_is_default,
    output logic [tstab_pkg::INDEX_W-1:0]              o_seg_index,
    output logic [tstab_pkg::COUNT_W-1:0]              o_seg_count,
    output logic [1:0]                                 o_status
);
    import tstab_pkg::*;

    localparam int unsigned IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

    t_entry r_mem [MAX_SEGMENTS];
    t_entry r_rdata;
    t_entry r_hit;

    logic [1:0]        r_op;
    logic [TIME_W-1:0] r_time;
    logic [BPM_W-1:0]  r_bpm;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_pos, n_pos;
    logic [BPM_W-1:0]  r_cfg_bpm;
    logic [TIME_W-1:0] r_cfg_ofs;
    logic              r_out_valid;

    logic [CW-1:0] raddr_full;
    logic [IW-1:0] raddr, waddr;
    t_entry        wdata;
    logic [CW:0]   idx_p1;
    logic [31:0]   pos_ext, cnt_ext;

    // addresses and write data
    always_comb begin
        case (i_cmd.rd_sel)
            RD_IDX_M1: raddr_full = r_idx - CW'(1);
            RD_IDX_P1: raddr_full = r_idx + CW'(1);
            default:   raddr_full = r_idx;
        endcase
        raddr = raddr_full[IW-1:0];
        waddr = r_idx[IW-1:0];
        if (i_cmd.wr_sel == WR_NEW) begin
            wdata.start = r_time;
            wdata.bpm   = r_bpm;
        end else begin
            wdata = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[raddr];
        end
        if (i_cmd.hit_cap) begin
            r_hit <= r_rdata;
        end
        if (i_cmd.load_item) begin
            r_op   <= i_op;
            r_time <= i_time_ms;
            r_bpm  <= (i_tempo_bpm == '0) ? INSERT_BPM_FALLBACK : i_tempo_bpm;
        end
    end

    // counters
    always_comb begin
        case (i_cmd.idx_op)
            IDX_CLR:   n_idx = '0;
            IDX_INC:   n_idx = r_idx + CW'(1);
            IDX_DEC:   n_idx = r_idx - CW'(1);
            IDX_COUNT: n_idx = r_count;
            IDX_POS:   n_idx = r_pos;
            default:   n_idx = r_idx;
        endcase
        case (i_cmd.pos_op)
            POS_IDX:  n_pos = r_idx;
            POS_DEC:  n_pos = r_pos - CW'(1);
            POS_LAST: n_pos = r_count - CW'(1);
            default:  n_pos = r_pos;
        endcase
        case (i_cmd.cnt_op)
            CNT_INC: n_count = r_count + CW'(1);
            CNT_DEC: n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_pos     <= '0;
            r_cfg_bpm <= RESET_DEFAULT_BPM;
            r_cfg_ofs <= RESET_DEFAULT_OFS;
        end else begin
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pos   <= n_pos;
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    CFG_DEFAULT_BPM: r_cfg_bpm <= i_cfg_data[BPM_W-1:0];
                    CFG_DEFAULT_OFS: r_cfg_ofs <= i_cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // status to the sequencer
    assign idx_p1 = {1'b0, r_idx} + (CW+1)'(1);

    always_comb begin
        o_stat.op            = r_op;
        o_stat.cnt_zero      = (r_count == '0);
        o_stat.cnt_one       = (r_count == CW'(1));
        o_stat.full          = (r_count >= CW'(MAX_SEGMENTS));
        o_stat.less          = (r_time < r_rdata.start);
        o_stat.idx_eq_cnt    = (r_idx == r_count);
        o_stat.idx_eq_pos    = (r_idx == r_pos);
        o_stat.idx_p1_lt_cnt = (idx_p1 < {1'b0, r_count});
        o_stat.pos_zero      = (r_pos == '0);
        o_stat.pos_eq_cnt    = (r_pos == r_count);
        o_stat.out_free      = !r_out_valid || i_out_ready;
    end

    // result register
    assign pos_ext = 32'(r_pos);
    assign cnt_ext = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            o_seg_count <= cnt_ext[COUNT_W-1:0];
            case (i_cmd.res_sel)
                RES_HIT: begin
                    o_seg_bpm      <= r_hit.bpm;
                    o_seg_start_ms <= {1'b0, r_hit.start};
                    o_is_default   <= 1'b0;
                    o_seg_index    <= pos_ext[INDEX_W-1:0];
                    o_status       <= STAT_OK;
                end
                RES_NEW: begin
                    o_seg_bpm      <= r_bpm;
                    o_seg_start_ms <= {1'b0, r_time};
                    o_is_default   <= 1'b0;
                    o_seg_index    <= pos_ext[INDEX_W-1:0];
                    o_status       <= STAT_OK;
                end
                RES_FULL: begin
                    o_seg_bpm      <= r_bpm;
                    o_seg_start_ms <= {1'b0, r_time};
                    o_is_default   <= 1'b0;
                    o_seg_index    <= '0;
                    o_status       <= STAT_FULL;
                end
                RES_EMPTY: begin
                    o_seg_bpm      <= r_cfg_bpm;
                    o_seg_start_ms <= {r_cfg_ofs[TIME_W-1], r_cfg_ofs};
                    o_is_default   <= 1'b1;
                    o_seg_index    <= '0;
                    o_status       <= STAT_EMPTY;
                end
                default: begin
                    o_seg_bpm      <= r_cfg_bpm;
                    o_seg_start_ms <= {r_cfg_ofs[TIME_W-1], r_cfg_ofs};
                    o_is_default   <= 1'b1;
                    o_seg_index    <= '0;
                    o_status       <= STAT_OK;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== sim/tb_tempo_segment_table_unit.sv =====
// testbench of the sorted tempo segment table: random and directed operations vs a shadow model
`timescale 1ns / 100ps

module tb_tempo_segment_table_unit;
    import tstab_pkg::*;

    localparam int unsigned SEG_DEPTH     = MAX_SEGMENTS_DEF;
    localparam int unsigned SETTLE_CYCLES = 100;
    localparam int unsigned HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int unsigned PHASE_ITEMS   = 125;
    localparam int unsigned NUM_PHASES    = 4;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned IDLE_PCT      = 22;

    // op code 3 and register indexes 2 and 3 are not named by the package
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [BPM_W-1:0]  BPM_MAX  = {BPM_W{1'b1}};

    // one expected result transaction
    typedef struct {
        logic [BPM_W-1:0]          bpm;
        logic signed [START_W-1:0] start;
        logic                      dflt;
        logic [INDEX_W-1:0]        idx;
        logic [COUNT_W-1:0]        count;
        t_status                   status;
    } t_seg_result;

    // shadow copy of the segment table and defaults, plus the results still owed
    class segment_table_shadow;
        logic [TIME_W-1:0] held_start [SEG_DEPTH];
        logic [BPM_W-1:0]  held_bpm   [SEG_DEPTH];
        int unsigned       held_count;
        logic [BPM_W-1:0]  dflt_bpm;
        logic [TIME_W-1:0] dflt_ofs;
        t_seg_result       awaited_results [$];
        int unsigned       faults;

        function new();
            held_count = 0;
            dflt_bpm   = RESET_DEFAULT_BPM;
            dflt_ofs   = RESET_DEFAULT_OFS;
            faults     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_DEFAULT_BPM)
                dflt_bpm = data[BPM_W-1:0];
            else if (idx == CFG_DEFAULT_OFS)
                dflt_ofs = data[TIME_W-1:0];
        endfunction

        function int unsigned outstanding();
            return awaited_results.size();
        endfunction

        function logic [TIME_W-1:0] pick_held_start();
            if (held_count == 0)
                return TIME_W'($urandom());
            return held_start[$urandom_range(held_count - 1)];
        endfunction

        // first position whose start lies strictly after t
        function int unsigned first_later(logic [TIME_W-1:0] t);
            for (int unsigned i = 0; i < held_count; i++)
                if (t < held_start[i])
                    return i;
            return held_count;
        endfunction

        function t_seg_result default_answer(t_status st);
            t_seg_result r;
            r.bpm    = dflt_bpm;
            r.start  = {dflt_ofs[TIME_W-1], dflt_ofs};
            r.dflt   = 1'b1;
            r.idx    = '0;
            r.count  = held_count[COUNT_W-1:0];
            r.status = st;
            return r;
        endfunction

        // apply one accepted operation and queue the result it must produce
        function void note_op(logic [1:0] op, logic [TIME_W-1:0] t, logic [BPM_W-1:0] bpm);
            t_seg_result r;
            int unsigned pos;
            logic [BPM_W-1:0]  gone_bpm;
            logic [TIME_W-1:0] gone_start;
            if (op == OP_INSERT) begin
                if (bpm == '0)
                    bpm = INSERT_BPM_FALLBACK;
                r.bpm   = bpm;
                r.start = {1'b0, t};
                r.dflt  = 1'b0;
                if (held_count >= SEG_DEPTH) begin
                    // table full: nothing stored
                    r.idx    = '0;
                    r.status = STAT_FULL;
                end else begin
                    pos = first_later(t);
                    for (int unsigned j = held_count; j > pos; j--) begin
                        held_start[j] = held_start[j-1];
                        held_bpm[j]   = held_bpm[j-1];
                    end
                    held_start[pos] = t;
                    held_bpm[pos]   = bpm;
                    held_count++;
                    r.idx    = pos[INDEX_W-1:0];
                    r.status = STAT_OK;
                end
                r.count = held_count[COUNT_W-1:0];
            end else if (op == OP_REMOVE) begin
                if (held_count == 0) begin
                    r = default_answer(STAT_EMPTY);
                end else begin
                    if (held_count == 1) begin
                        pos = 0;
                    end else begin
                        pos = first_later(t);
                        if (pos == held_count)
                            pos = held_count - 1;
                        else if (pos > 0)
                            pos--;
                    end
                    gone_bpm   = held_bpm[pos];
                    gone_start = held_start[pos];
                    for (int unsigned j = pos; j + 1 < held_count; j++) begin
                        held_start[j] = held_start[j+1];
                        held_bpm[j]   = held_bpm[j+1];
                    end
                    held_count--;
                    r.bpm    = gone_bpm;
                    r.start  = {1'b0, gone_start};
                    r.dflt   = 1'b0;
                    r.idx    = pos[INDEX_W-1:0];
                    r.count  = held_count[COUNT_W-1:0];
                    r.status = STAT_OK;
                end
            end else begin
                // lookup, spare op code included
                pos = first_later(t);
                if (held_count == 0 || pos == 0) begin
                    r = default_answer(STAT_OK);
                end else begin
                    pos--;
                    r.bpm    = held_bpm[pos];
                    r.start  = {1'b0, held_start[pos]};
                    r.dflt   = 1'b0;
                    r.idx    = pos[INDEX_W-1:0];
                    r.count  = held_count[COUNT_W-1:0];
                    r.status = STAT_OK;
                end
            end
            awaited_results.push_back(r);
        endfunction

        function void check_result(logic [BPM_W-1:0] bpm, logic signed [START_W-1:0] start,
                                   logic dflt, logic [INDEX_W-1:0] idx,
                                   logic [COUNT_W-1:0] count, logic [1:0] status);
            t_seg_result want;
            if (awaited_results.size() == 0) begin
                $error("result transaction with no operation pending");
                faults++;
                return;
            end
            want = awaited_results.pop_front();
            if (bpm !== want.bpm) begin
                $error("seg_bpm expected %0d actual %0d", want.bpm, bpm);
                faults++;
            end
            if (start !== want.start) begin
                $error("seg_start_ms expected %0d actual %0d", want.start, start);
                faults++;
            end
            if (dflt !== want.dflt) begin
                $error("is_default expected %0d actual %0d", want.dflt, dflt);
                faults++;
            end
            if (idx !== want.idx) begin
                $error("seg_index expected %0d actual %0d", want.idx, idx);
                faults++;
            end
            if (count !== want.count) begin
                $error("seg_count expected %0d actual %0d", want.count, count);
                faults++;
            end
            if (status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, status);
                faults++;
            end
        endfunction
    endclass

    // clock, reset and block ports
    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [1:0]              i_op;
    logic [TIME_W-1:0]       i_time_ms;
    logic [BPM_W-1:0]        i_tempo_bpm;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [BPM_W-1:0]        o_seg_bpm;
    logic signed [START_W-1:0] o_seg_start_ms;
    logic                    o_is_default;
    logic [INDEX_W-1:0]      o_seg_index;
    logic [COUNT_W-1:0]      o_seg_count;
    logic [1:0]              o_status;

    // stimulus controls shared between the sender and receiver processes
    logic        calm;        // no idling on either side while set
    logic        hold_req;    // asks the receiver for one long hold-off
    int unsigned cycle_count;

    segment_table_shadow shadow = new();

    tempo_segment_table_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_time_ms      (i_time_ms),
        .i_tempo_bpm    (i_tempo_bpm),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_seg_bpm      (o_seg_bpm),
        .o_seg_start_ms (o_seg_start_ms),
        .o_is_default   (o_is_default),
        .o_seg_index    (o_seg_index),
        .o_seg_count    (o_seg_count),
        .o_status       (o_status)
    );

    always #6 i_clk = ~i_clk;

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tempo_segment_table_unit verification failed");
            $finish;
        end
    end

    // result monitor: outputs sampled at the rising edge, before the block updates them
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            shadow.check_result(o_seg_bpm, o_seg_start_ms, o_is_default,
                                o_seg_index, o_seg_count, o_status);
    end

    // receiver: random back-pressure, one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // offer one operation transaction; entered and left at a falling edge
    task automatic offer_op(input logic [1:0] op, input logic [TIME_W-1:0] t,
                            input logic [BPM_W-1:0] bpm);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_time_ms   <= t;
        i_tempo_bpm <= bpm;
        do @(posedge i_clk); while (!o_in_ready);
        shadow.note_op(op, t, bpm);
        @(negedge i_clk);
    endtask

    // stop offering and wait until every owed result has drained, then settle
    task automatic await_drain();
        i_in_valid <= 1'b0;
        while (shadow.outstanding() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // one register write transaction, valid dropped again after it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // times cluster on held starts and small values so equal and exact hits happen often
    function automatic logic [TIME_W-1:0] pick_time();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30)
            return shadow.pick_held_start() + TIME_W'($urandom_range(2)) - TIME_W'(1);
        if (r < 55)
            return TIME_W'($urandom_range(5000));
        if (r < 62)
            return '0;
        if (r < 69)
            return TIME_MAX;
        return TIME_W'($urandom());
    endfunction

    function automatic logic [BPM_W-1:0] pick_bpm();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 12)
            return '0;
        if (r < 18)
            return BPM_MAX;
        return BPM_W'($urandom_range(1023));
    endfunction

    // blocks of forty alternate between filling and draining the table
    function automatic logic [1:0] pick_op(int unsigned k);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3)
            return OP_SPARE;
        if (((k / 40) % 2) == 0)
            return (r < 60) ? OP_INSERT : (r < 80) ? OP_LOOKUP : OP_REMOVE;
        return (r < 22) ? OP_INSERT : (r < 45) ? OP_LOOKUP : OP_REMOVE;
    endfunction

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_op        = OP_LOOKUP;
        i_time_ms   = '0;
        i_tempo_bpm = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_DEFAULT_BPM;
        i_cfg_data  = '0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        cycle_count = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table under the reset defaults
        offer_op(OP_LOOKUP, '0, '0);
        offer_op(OP_REMOVE, 24'd77, '0);
        offer_op(OP_SPARE, TIME_MAX, BPM_MAX);
        await_drain();

        // smallest tempo and most negative offset
        write_reg(CFG_DEFAULT_BPM, 24'd1);
        write_reg(CFG_DEFAULT_OFS, 24'h800000);

        offer_op(OP_LOOKUP, '0, '0);                 // default answer, negative offset
        offer_op(OP_INSERT, 24'd1000, '0);           // zero tempo falls back
        offer_op(OP_INSERT, 24'd1000, BPM_MAX);      // equal start goes after
        offer_op(OP_INSERT, '0, 10'd1);
        offer_op(OP_INSERT, TIME_MAX, 10'd512);
        offer_op(OP_LOOKUP, '0, '0);                 // exact hit on first
        offer_op(OP_LOOKUP, 24'd999, '0);
        offer_op(OP_LOOKUP, 24'd1000, '0);           // last of the equal starts
        offer_op(OP_LOOKUP, TIME_MAX, '0);
        offer_op(OP_SPARE, 24'd500, '0);             // spare code acts as lookup
        offer_op(OP_REMOVE, TIME_MAX, '0);           // at or past last start
        offer_op(OP_REMOVE, '0, '0);                 // covering segment
        offer_op(OP_LOOKUP, 24'd5, '0);              // before every start
        offer_op(OP_REMOVE, 24'd5, '0);              // before every start removes the first
        offer_op(OP_REMOVE, '0, '0);                 // single entry goes whatever the time
        offer_op(OP_REMOVE, 24'd1234, '0);           // empty table
        offer_op(OP_INSERT, 24'h555555, 10'h2AA);
        offer_op(OP_INSERT, 24'hAAAAAA, 10'h155);
        offer_op(OP_LOOKUP, 24'hAAAAAA, '0);
        await_drain();

        // largest tempo and offset; spare indexes must change nothing
        write_reg(CFG_DEFAULT_BPM, 24'd1023);
        write_reg(CFG_DEFAULT_OFS, 24'h7FFFFF);
        write_reg(CFG_SPARE_A, 24'hFFFFFF);
        write_reg(CFG_SPARE_B, 24'h000001);

        for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
            calm = (ph == 1);
            // receiver stalls long while items keep coming, so the input backs up
            if (ph == 2)
                hold_req = 1'b1;
            for (int unsigned k = 0; k < PHASE_ITEMS; k++)
                offer_op(pick_op(k), pick_time(), pick_bpm());
            await_drain();
            if (ph == 0) begin
                write_reg(CFG_DEFAULT_BPM, {14'd0, RESET_DEFAULT_BPM});
                write_reg(CFG_DEFAULT_OFS, RESET_DEFAULT_OFS);
            end else begin
                write_reg(CFG_DEFAULT_BPM, CFG_DATA_W'($urandom_range(1023, 1)));
                write_reg(CFG_DEFAULT_OFS, CFG_DATA_W'($urandom()));
            end
        end
        calm = 1'b0;

        offer_op(OP_LOOKUP, TIME_W'($urandom()), '0);
        await_drain();

        if (shadow.faults == 0 && shadow.outstanding() == 0) begin
            $display("tempo_segment_table_unit verification clean");
        end else begin
            $display("tempo_segment_table_unit verification failed");
        end
        $finish;
    end

endmodule
